// ===== hw/rtl/ppg_pkg.sv =====
// Shared types, register codes and cosine table builder for the plaid pixel generator.
package ppg_pkg;

  localparam int unsigned StepBits    = 32;
  localparam int unsigned AmpBits     = 16;
  localparam int unsigned LevelBits   = 8;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned NumStages   = 5;

  localparam logic [AmpBits-1:0] BaseReset = 16'h8000;

  localparam longint unsigned Q30One    = 64'd1 << 30;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned QHalf     = 64'd1 << 29;

  // Divisors of the successive Taylor terms: (2k-1)(2k) for cosine, (2k)(2k+1) for sine.
  localparam longint unsigned CosDiv [7] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
                                             64'd182};
  localparam longint unsigned SinDiv [7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                             64'd210};

  typedef enum logic [CfgIdxBits-1:0] {
    REG_STEP_X_ONE = 3'd0,
    REG_STEP_Y_ONE = 3'd1,
    REG_STEP_X_TWO = 3'd2,
    REG_STEP_Y_TWO = 3'd3,
    REG_AMP_ONE    = 3'd4,
    REG_AMP_TWO    = 3'd5,
    REG_BASE_LEVEL = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [StepBits-1:0] step_x_one;
    logic [StepBits-1:0] step_y_one;
    logic [StepBits-1:0] step_x_two;
    logic [StepBits-1:0] step_y_two;
    logic [AmpBits-1:0]  amp_one;
    logic [AmpBits-1:0]  amp_two;
    logic [AmpBits-1:0]  base_level;
  } cfg_t;

  // Per-stage load enables and valid bits of the pixel pipeline.
  typedef struct packed {
    logic [NumStages-1:0] ld;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

  // Table entry idx of a cosine table with 2^tbits entries and cbits-bit signed values.
  // Only evaluated at elaboration.
  function automatic longint cos_entry(int unsigned idx, int tbits, int cbits);
    longint unsigned full;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned th;
    longint unsigned x2;
    longint unsigned tc;
    longint unsigned ts;
    longint unsigned cv;
    longint unsigned sv;
    longint unsigned mag;
    longint unsigned m;
    longint          acc_c;
    longint          acc_s;
    full  = (64'd1 << (cbits - 1)) - 64'd1;
    quad  = (64'(idx) >> (tbits - 2)) & 64'd3;
    rem   = 64'(idx) & ((64'd1 << (tbits - 2)) - 64'd1);
    th    = (rem * HalfPiQ30) >> (tbits - 2);
    x2    = (th * th) >> 30;
    tc    = Q30One;
    ts    = th;
    acc_c = longint'(Q30One);
    acc_s = longint'(th);
    for (int k = 0; k < 7; k++) begin
      tc = ((tc * x2) >> 30) / CosDiv[k];
      ts = ((ts * x2) >> 30) / SinDiv[k];
      if (k[0] == 1'b0) begin
        acc_c = acc_c - longint'(tc);
        acc_s = acc_s - longint'(ts);
      end else begin
        acc_c = acc_c + longint'(tc);
        acc_s = acc_s + longint'(ts);
      end
    end
    if (acc_c < 0) cv = 64'd0;
    else if (acc_c > longint'(Q30One)) cv = Q30One;
    else cv = acc_c;
    if (acc_s < 0) sv = 64'd0;
    else if (acc_s > longint'(Q30One)) sv = Q30One;
    else sv = acc_s;
    mag = (quad == 64'd0 || quad == 64'd2) ? cv : sv;
    m   = (mag * full + QHalf) >> 30;
    return (quad == 64'd1 || quad == 64'd2) ? -longint'(m) : longint'(m);
  endfunction

endpackage

// ===== hw/rtl/ppg_regs.sv =====
// Configuration register file of the plaid pixel generator.
module ppg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [ppg_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [ppg_pkg::CfgDataBits-1:0]     cfg_data_i,
  output ppg_pkg::cfg_t                       cfg_o
);

  ppg_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_x_one <= '0;
      cfg_q.step_y_one <= '0;
      cfg_q.step_x_two <= '0;
      cfg_q.step_y_two <= '0;
      cfg_q.amp_one    <= '0;
      cfg_q.amp_two    <= '0;
      cfg_q.base_level <= ppg_pkg::BaseReset;
    end else if (cfg_valid_i) begin
      // Indexes past the register list are dropped.
      unique case (ppg_pkg::reg_idx_e'(cfg_index_i))
        ppg_pkg::REG_STEP_X_ONE: cfg_q.step_x_one <= cfg_data_i;
        ppg_pkg::REG_STEP_Y_ONE: cfg_q.step_y_one <= cfg_data_i;
        ppg_pkg::REG_STEP_X_TWO: cfg_q.step_x_two <= cfg_data_i;
        ppg_pkg::REG_STEP_Y_TWO: cfg_q.step_y_two <= cfg_data_i;
        ppg_pkg::REG_AMP_ONE:    cfg_q.amp_one    <= cfg_data_i[ppg_pkg::AmpBits-1:0];
        ppg_pkg::REG_AMP_TWO:    cfg_q.amp_two    <= cfg_data_i[ppg_pkg::AmpBits-1:0];
        ppg_pkg::REG_BASE_LEVEL: cfg_q.base_level <= cfg_data_i[ppg_pkg::AmpBits-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ppg_ctrl.sv =====
// Valid bits and load enables of the pixel pipeline, with bubble collapsing.
module ppg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  output ppg_pkg::pipe_ctl_t  ctl_o
);

  localparam int unsigned N = ppg_pkg::NumStages;

  logic [N-1:0] vld_q, vld_d;
  logic [N-1:0] ld;

  // A stage may load when it is empty or when the stage after it is loading too.
  always_comb begin
    ld[N-1] = !vld_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_comb begin
    vld_d[0] = ld[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < N; k++) begin
      vld_d[k] = ld[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.ld  = ld;
  assign ctl_o.vld = vld_q;

  // A result that is not taken stays in the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[N-1] && !out_ready_i |=> vld_q[N-1])
    else $error("output result lost while stalled");

  // Any empty stage lets the input side take a new pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld_q) |-> ld[0])
    else $error("input blocked although the pipeline has a bubble");

  // The first stage only holds when the stage after it is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !ld[0] |-> vld_q[1])
    else $error("first stage held in front of an empty stage");

endmodule

// ===== hw/rtl/ppg_phase.sv =====
// Grating phase: coordinate products, then wrapped phase sum and table address.
module ppg_phase #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                          clk_i,
  input  ppg_pkg::cfg_t                 cfg_i,
  input  ppg_pkg::pipe_ctl_t            ctl_i,
  input  logic signed [COORD_BITS-1:0]  dx_i,
  input  logic signed [COORD_BITS-1:0]  dy_i,
  output logic [TABLE_BITS-1:0]         addr_one_o,
  output logic [TABLE_BITS-1:0]         addr_two_o
);

  localparam int unsigned SB = ppg_pkg::StepBits;
  localparam int unsigned PW = SB + COORD_BITS;

  logic signed [PW-1:0] mx1, my1, mx2, my2;
  logic [SB-1:0]        px1_q, py1_q, px2_q, py2_q;
  logic [SB-1:0]        ph1, ph2;
  logic [TABLE_BITS-1:0] addr1_q, addr2_q;

  // Only the low word of each product matters: the phase wraps once per grating period.
  assign mx1 = PW'(signed'(cfg_i.step_x_one)) * PW'(dx_i);
  assign my1 = PW'(signed'(cfg_i.step_y_one)) * PW'(dy_i);
  assign mx2 = PW'(signed'(cfg_i.step_x_two)) * PW'(dx_i);
  assign my2 = PW'(signed'(cfg_i.step_y_two)) * PW'(dy_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[0]) begin
      px1_q <= mx1[SB-1:0];
      py1_q <= my1[SB-1:0];
      px2_q <= mx2[SB-1:0];
      py2_q <= my2[SB-1:0];
    end
  end

  assign ph1 = px1_q + py1_q;
  assign ph2 = px2_q + py2_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[1]) begin
      addr1_q <= ph1[SB-1 -: TABLE_BITS];
      addr2_q <= ph2[SB-1 -: TABLE_BITS];
    end
  end

  assign addr_one_o = addr1_q;
  assign addr_two_o = addr2_q;

endmodule

// ===== hw/rtl/ppg_cos_rom.sv =====
// Cosine table with two registered read ports, contents built at elaboration.
module ppg_cos_rom #(
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned COS_BITS   = 16
) (
  input  logic                        clk_i,
  input  logic                        ld_i,
  input  logic [TABLE_BITS-1:0]       addr_a_i,
  input  logic [TABLE_BITS-1:0]       addr_b_i,
  output logic signed [COS_BITS-1:0]  cos_a_o,
  output logic signed [COS_BITS-1:0]  cos_b_o
);

  localparam int unsigned RomSize = 1 << TABLE_BITS;

  typedef logic signed [COS_BITS-1:0] rom_t [RomSize];

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int unsigned i = 0; i < RomSize; i++) begin
      tbl[i] = COS_BITS'(ppg_pkg::cos_entry(i, TABLE_BITS, COS_BITS));
    end
    return tbl;
  endfunction

  localparam rom_t Rom = build_rom();

  logic signed [COS_BITS-1:0] cos_a_q, cos_b_q;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      cos_a_q <= Rom[addr_a_i];
      cos_b_q <= Rom[addr_b_i];
    end
  end

  assign cos_a_o = cos_a_q;
  assign cos_b_o = cos_b_q;

endmodule

// ===== hw/rtl/ppg_mix.sv =====
// Amplitude products, then level sum with truncation and saturation to 0..255.
module ppg_mix #(
  parameter int unsigned COS_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ppg_pkg::cfg_t                     cfg_i,
  input  ppg_pkg::pipe_ctl_t                ctl_i,
  input  logic signed [COS_BITS-1:0]        cos_one_i,
  input  logic signed [COS_BITS-1:0]        cos_two_i,
  output logic [ppg_pkg::LevelBits-1:0]     level_o,
  output logic                              clipped_o
);

  localparam int unsigned AB = ppg_pkg::AmpBits;
  localparam int unsigned LB = ppg_pkg::LevelBits;
  localparam int unsigned F  = COS_BITS - 1;
  localparam int unsigned PW = COS_BITS + AB + 1;
  localparam int unsigned SW = COS_BITS + AB + 2;
  localparam int unsigned LastStage = ppg_pkg::NumStages - 1;

  logic signed [PW-1:0] m1, m2;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [SW-1:0] base_ext, sum;
  logic [LB-1:0]        level_q, level_d;
  logic                 clip_q, clip_d;

  assign m1 = PW'(signed'({1'b0, cfg_i.amp_one})) * PW'(cos_one_i);
  assign m2 = PW'(signed'({1'b0, cfg_i.amp_two})) * PW'(cos_two_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[LastStage-1]) begin
      p1_q <= m1;
      p2_q <= m2;
    end
  end

  assign base_ext = signed'(SW'({cfg_i.base_level, F'(0)}));
  assign sum      = base_ext + SW'(p1_q) + SW'(p2_q);

  // Bits above the integer level show a sum of 256.0 or more.
  always_comb begin
    if (sum[SW-1]) begin
      level_d = '0;
      clip_d  = 1'b1;
    end else if (|sum[SW-2:F+8+LB]) begin
      level_d = '1;
      clip_d  = 1'b1;
    end else begin
      level_d = sum[F+8+LB-1:F+8];
      clip_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[LastStage]) begin
      level_q <= level_d;
      clip_q  <= clip_d;
    end
  end

  assign level_o   = level_q;
  assign clipped_o = clip_q;

  // A clipped result always sits at one of the two rails.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.vld[LastStage] && clip_q |-> (level_q == '0 || level_q == '1))
    else $error("clipped level not at a rail");

endmodule

// ===== hw/rtl/plaid_pixel_generator.sv =====
// Plaid pixel generator: two cosine gratings summed into one saturated 8-bit level.
//
// Usage: pixel offsets from the plaid center enter on the s_axis channel, one transfer
// per pixel; each produces exactly one level on the m_axis channel, in order.
// The configuration channel (cfg_valid_i, cfg_index_i, cfg_data_i) writes the grating
// steps, amplitudes and base level; it is always ready. It is to be written while the
// pipeline is empty; the block does not enforce this. Indexes past the last register are ignored.
// The pipeline runs from input transfer to output valid through: coordinate products,
// phase sum and table address, cosine table read, amplitude products, level sum and
// saturation. Throughput is one pixel per cycle while m_axis is not stalled, set by the
// five-stage pipeline in which every stage loads once per cycle unless stalled.
// Reset empties the pipeline, clears steps and amplitudes and sets the base level to
// 128.0. The cosine table is constant and needs no clearing.
// When the receiver stalls, the result holds on m_axis and earlier stages keep filling
// until every stage is full; only then does s_axis_tready drop.
module plaid_pixel_generator #(
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned COS_BITS   = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: dx, dy, zero padding.
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Fields from bit 0: level.
  output logic [ppg_pkg::LevelBits-1:0]         m_axis_tdata,
  // Fields from bit 0: clipped.
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ppg_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [ppg_pkg::CfgDataBits-1:0]       cfg_data_i
);

  ppg_pkg::cfg_t        cfg;
  ppg_pkg::pipe_ctl_t   ctl;
  logic signed [COORD_BITS-1:0] dx, dy;
  logic [TABLE_BITS-1:0]        addr_one, addr_two;
  logic signed [COS_BITS-1:0]   cos_one, cos_two;

  assign cfg_ready_o = 1'b1;

  assign dx = signed'(s_axis_tdata[COORD_BITS-1:0]);
  assign dy = signed'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);

  ppg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  ppg_phase #(
    .COORD_BITS (COORD_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_phase (
    .clk_i      (clk_i),
    .cfg_i      (cfg),
    .ctl_i      (ctl),
    .dx_i       (dx),
    .dy_i       (dy),
    .addr_one_o (addr_one),
    .addr_two_o (addr_two)
  );

  ppg_cos_rom #(
    .TABLE_BITS (TABLE_BITS),
    .COS_BITS   (COS_BITS)
  ) u_cos_rom (
    .clk_i    (clk_i),
    .ld_i     (ctl.ld[2]),
    .addr_a_i (addr_one),
    .addr_b_i (addr_two),
    .cos_a_o  (cos_one),
    .cos_b_o  (cos_two)
  );

  ppg_mix #(
    .COS_BITS (COS_BITS)
  ) u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .ctl_i     (ctl),
    .cos_one_i (cos_one),
    .cos_two_i (cos_two),
    .level_o   (m_axis_tdata),
    .clipped_o (m_axis_tuser)
  );

  assign s_axis_tready = ctl.ld[0];
  assign m_axis_tvalid = ctl.vld[ppg_pkg::NumStages-1];

endmodule
